// ----- hdl/nsp_pkg.sv -----
// Package for the note sequence player: item types, op and event codes,
// controller commands. No dependencies.
`default_nettype none
package nsp_pkg;
  localparam int MaxNotes = 64;
  localparam int IdxW = 6;
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_WRITE = 2'd1,
    OP_COMMIT = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_ON = 2'd1,
    EV_OFF = 2'd2
  } gate_ev_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] tick_time;
    logic [5:0]         entry_index;
    logic signed [31:0] note_start;
    logic signed [31:0] note_end;
    logic signed [31:0] note_value;
    logic signed [31:0] seq_offset;
    logic [30:0]        seq_length;
    logic               seq_repeat;
    logic [6:0]         note_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         gate_event;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic write;
    logic commit;
    logic pre;
    logic pass;
    logic rd;
    logic walk;
    logic done;
  } nsp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic pass_loop;
    logic walk_more;
  } nsp_sts_t;
endpackage
`default_nettype wire

// ----- hdl/note_sequence_player_top.sv -----
// Note sequence player: one item at a time. A write or commit item holds busy only
// in the execute state and gives no result. A tick holds busy through the pre, pass
// and walk states, with a further pass when a pending sequence is swapped in on the
// first pass; the walk reads note entries through the registered memory read port.
// Only a tick gives a result strobe, in the cycle busy falls; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all sequence state; note memories are not.
`default_nettype none
module note_sequence_player_top import nsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item_i,
  output logic          valid_o,
  output out_item_t     res_o
);
  nsp_cmd_t cmd;
  nsp_sts_t sts;
  out_item_t res;
  logic vld;

  nsp_ctrl u_ctrl (.clk_i, .rst_ni, .start_i(start), .sts_i(sts), .busy_o(busy),
                   .valid_o(vld), .cmd_o(cmd));
  nsp_datapath u_dp (.clk_i, .rst_ni, .item_i, .cmd_i(cmd), .sts_o(sts), .res_o(res));

  assign valid_o = vld;
  assign res_o = res;
endmodule
`default_nettype wire

// ----- hdl/nsp_datapath.sv -----
// Datapath of the note sequence player: note memories, sequence state, position
// arithmetic and table walk. Depends on nsp_pkg.
`default_nettype none
module nsp_datapath import nsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  item_i,
  input  wire nsp_cmd_t  cmd_i,
  output nsp_sts_t       sts_o,
  output out_item_t      res_o
);
  logic [31:0] st_mem [2*MaxNotes];
  logic [31:0] en_mem [2*MaxNotes];
  logic [31:0] va_mem [2*MaxNotes];
  logic [31:0] st_rd_q, en_rd_q, va_rd_q;

  in_item_t item_q;
  logic bank_q, act_q, pend_q, started_q, gate_q, rep_a_q, rep_p_q;
  logic signed [31:0] last_q, posoff_q, held_q, off_a_q, off_p_q;
  logic [30:0] len_a_q, len_p_q;
  logic [6:0] cnt_a_q, cnt_p_q, ptr_q;
  logic [1:0] ev_q, pass_q;
  logic loop_q, fin_q;
  logic signed [32:0] pos_q;

  logic signed [33:0] t_x, last_x, ceil_x, sum_x, len_x, fake_x;
  logic [6:0] cnt_clamp;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    t_x = 34'(item_q.tick_time);
    last_x = 34'(last_q);
    ceil_x = (last_q[FracBits-1:0] != '0) ?
             34'($signed({last_q[31:FracBits], {FracBits{1'b0}}})) + (34'sd1 <<< FracBits) :
             last_x;
    len_x = 34'($signed({1'b0, len_a_q}));
    fake_x = 34'($signed({1'b0, len_a_q[FracBits-1:0]})) +
             34'($signed({item_q.tick_time[31:FracBits], {FracBits{1'b0}}}));
    sum_x = 34'(posoff_q) + ((t_x < last_x) ? ceil_x : 34'sd0);
    cnt_clamp = (item_q.note_count > 7'(MaxNotes)) ? 7'(MaxNotes) : item_q.note_count;
  end

  assign sts_o.is_tick = (item_q.op == OP_TICK);
  assign sts_o.pass_loop = loop_q;
  assign sts_o.walk_more = !fin_q && (ptr_q < cnt_a_q);
  assign res_o.out_value = held_q;
  assign res_o.gate_event = ev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && item_q.op == OP_WRITE) begin
      st_mem[{~bank_q, item_q.entry_index}] <= item_q.note_start;
      en_mem[{~bank_q, item_q.entry_index}] <= item_q.note_end;
      va_mem[{~bank_q, item_q.entry_index}] <= item_q.note_value;
    end
    if (cmd_i.rd) begin
      st_rd_q <= st_mem[{bank_q, ptr_q[IdxW-1:0]}];
      en_rd_q <= en_mem[{bank_q, ptr_q[IdxW-1:0]}];
      va_rd_q <= va_mem[{bank_q, ptr_q[IdxW-1:0]}];
    end
    if (cmd_i.load) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0; act_q <= 1'b0; pend_q <= 1'b0; started_q <= 1'b0;
      gate_q <= 1'b0; rep_a_q <= 1'b0; rep_p_q <= 1'b0;
      last_q <= '0; posoff_q <= '0; held_q <= '0; off_a_q <= '0; off_p_q <= '0;
      len_a_q <= '0; len_p_q <= '0; cnt_a_q <= '0; cnt_p_q <= '0; ptr_q <= '0;
      ev_q <= EV_NONE; pass_q <= '0; loop_q <= 1'b0; fin_q <= 1'b0; pos_q <= '0;
    end else begin
      if (cmd_i.commit && item_q.op == OP_COMMIT) begin
        off_p_q <= item_q.seq_offset; len_p_q <= item_q.seq_length;
        rep_p_q <= item_q.seq_repeat; cnt_p_q <= cnt_clamp; pend_q <= 1'b1;
      end
      if (cmd_i.pre) begin
        ev_q <= EV_NONE; pass_q <= '0; fin_q <= 1'b0; loop_q <= 1'b1;
        if (!act_q) begin
          if (!pend_q) begin
            last_q <= item_q.tick_time;
            if (gate_q) begin gate_q <= 1'b0; ev_q <= EV_OFF; end
            fin_q <= 1'b1; loop_q <= 1'b0;
          end else begin
            bank_q <= ~bank_q; act_q <= 1'b1; pend_q <= 1'b0; started_q <= 1'b0;
            off_a_q <= off_p_q; len_a_q <= len_p_q; rep_a_q <= rep_p_q;
            cnt_a_q <= cnt_p_q;
          end
        end
      end
      if (cmd_i.pass) begin
        pass_q <= pass_q + 2'd1;
        loop_q <= 1'b0;
        if (!loop_q && pass_q != 2'd0) begin
          pos_q <= 33'(item_q.tick_time) + 33'(posoff_q);
        end else if (!started_q && !(item_q.tick_time <= off_a_q ||
                                     item_q.tick_time < last_q)) begin
          last_q <= item_q.tick_time;
          if (gate_q) begin gate_q <= 1'b0; ev_q <= EV_OFF; end
          fin_q <= 1'b1;
        end else begin : pass_body
          logic signed [31:0] po;
          logic st;
          st = !started_q;
          po = st ? sat(-34'(off_a_q)) : posoff_q;
          if (st) begin started_q <= 1'b1; ptr_q <= '0; end
          if (!st && item_q.tick_time < last_q) po = sat(sum_x);
          last_q <= item_q.tick_time;
          if (34'(item_q.tick_time) + 34'(po) < len_x) begin
            posoff_q <= po;
          end else begin
            if (gate_q) begin gate_q <= 1'b0; ev_q <= EV_OFF; end
            if (pend_q) begin
              bank_q <= ~bank_q; pend_q <= 1'b0; started_q <= 1'b0;
              off_a_q <= off_p_q; len_a_q <= len_p_q; rep_a_q <= rep_p_q;
              cnt_a_q <= cnt_p_q; posoff_q <= '0;
              if (fake_x <= 34'(off_p_q)) begin
                started_q <= 1'b1; ptr_q <= '0;
                posoff_q <= sat(-34'(off_p_q));
              end
              loop_q <= (pass_q == 2'd0);
            end else if (rep_a_q) begin
              posoff_q <= sat(34'(po) - len_x); ptr_q <= '0;
            end else begin
              posoff_q <= po; act_q <= 1'b0; fin_q <= 1'b1;
            end
          end
        end
      end
      if (cmd_i.walk) begin
        if (34'(pos_q) >= 34'($signed(en_rd_q))) begin
          ptr_q <= ptr_q + 7'd1; gate_q <= 1'b0; ev_q <= EV_OFF;
        end else begin
          fin_q <= 1'b1;
          if (34'(pos_q) >= 34'($signed(st_rd_q))) begin
            held_q <= va_rd_q;
            if (!gate_q) begin gate_q <= 1'b1; ev_q <= EV_ON; end
          end else if (gate_q) begin
            gate_q <= 1'b0; ev_q <= EV_OFF;
          end
        end
      end
      if (cmd_i.done && !fin_q && gate_q) begin
        gate_q <= 1'b0; ev_q <= EV_OFF;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/nsp_ctrl.sv -----
// Controller state machine of the note sequence player: sequences one item
// through load, pass, table walk and result. Depends on nsp_pkg.
`default_nettype none
module nsp_ctrl import nsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire nsp_sts_t sts_i,
  output logic          busy_o,
  output logic          valid_o,
  output nsp_cmd_t      cmd_o
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_PRE  = 7'b0000100,
    S_PASS = 7'b0001000,
    S_RD   = 7'b0010000,
    S_WALK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] pc_q, pc_d;
  logic valid_q;

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    cmd_o = '0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: if (start_i) begin cmd_o.load = 1'b1; state_d = S_EXEC; end
      S_EXEC: begin
        cmd_o.write = 1'b1; cmd_o.commit = 1'b1;
        state_d = sts_i.is_tick ? S_PRE : S_IDLE;
      end
      S_PRE: begin cmd_o.pre = 1'b1; pc_d = '0; state_d = S_PASS; end
      S_PASS: begin
        if (!sts_i.pass_loop && pc_q != 2'd0) begin
          cmd_o.pass = 1'b1; pc_d = 2'd2; state_d = S_RD;
        end else if (sts_i.walk_more || sts_i.pass_loop) begin
          cmd_o.pass = 1'b1; pc_d = pc_q + 2'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = sts_i.walk_more ? S_WALK : S_DONE;
      end
      S_WALK: begin cmd_o.walk = 1'b1; state_d = S_RD; end
      S_DONE: begin cmd_o.done = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_IDLE && start_i) busy_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pc_q <= '0; valid_q <= 1'b0;
    end else begin
      state_q <= state_d; pc_q <= pc_d; valid_q <= cmd_o.done;
    end
  end

  assign valid_o = valid_q;
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for note_sequence_player_top: random and directed items, a predictor
// of the note sequence player, and an in-order check of every result strobe.
// Depends on nsp_pkg and the top-level RTL.
`timescale 1ns / 100ps
module tb;
  import nsp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic valid_o;
  out_item_t res_o;

  note_sequence_player_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .valid_o(valid_o), .res_o(res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  localparam longint Beat = longint'(1) << FracBits;

  // Predictor state.
  logic [31:0] p_start [2*MaxNotes];
  logic [31:0] p_end [2*MaxNotes];
  logic [31:0] p_val [2*MaxNotes];
  bit p_bank, p_act, p_pend, p_started, p_gate, p_rep_a, p_rep_p;
  longint p_last, p_pos, p_off_a, p_len_a, p_off_p, p_len_p;
  int p_ptr, p_cnt_a, p_cnt_p;
  logic [31:0] p_held;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0, ticks_seen = 0, ons_seen = 0, offs_seen = 0;
  bit sender_done = 0, hold_sender = 0, paused_once = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint frac_of(longint x);
    return x & (Beat - 1);
  endfunction

  function automatic longint ceil_of(longint x);
    return frac_of(x) != 0 ? x - frac_of(x) + Beat : x;
  endfunction

  function automatic void swap_bank();
    p_bank ^= 1'b1; p_act = 1; p_pend = 0; p_started = 0;
    p_off_a = p_off_p; p_len_a = p_len_p; p_cnt_a = p_cnt_p; p_rep_a = p_rep_p;
  endfunction

  function automatic void begin_seq(longint t);
    p_started = 1; p_pos = sat32(-p_off_a); p_ptr = 0; p_last = t;
  endfunction

  function automatic gate_ev_e drop_gate(gate_ev_e ev);
    if (p_gate) begin
      p_gate = 0;
      return EV_OFF;
    end
    return ev;
  endfunction

  function automatic void push_result(gate_ev_e ev);
    out_item_t r;
    r.out_value = p_held;
    r.gate_event = ev;
    expected_results.push_back(r);
  endfunction

  function automatic void play_tick(longint t);
    gate_ev_e ev;
    longint fake, pos;
    int k;
    ev = EV_NONE;
    if (!p_act) begin
      if (!p_pend) begin
        p_last = t; push_result(drop_gate(EV_NONE)); return;
      end
      swap_bank();
    end
    for (int pass = 0; pass < 2; pass++) begin
      if (!p_started) begin
        if (t <= p_off_a || t < p_last) begin
          begin_seq(t);
        end else begin
          p_last = t; push_result(drop_gate(ev)); return;
        end
      end
      if (t < p_last) p_pos = sat32(p_pos + ceil_of(p_last));
      p_last = t;
      if (t + p_pos < p_len_a) break;
      ev = drop_gate(ev);
      if (p_pend) begin
        fake = frac_of(p_len_a) + (t - frac_of(t));
        swap_bank();
        p_pos = 0;
        if (fake <= p_off_a) begin_seq(t);
        continue;
      end
      if (p_rep_a) begin
        p_pos = sat32(p_pos - p_len_a); p_ptr = 0; break;
      end
      p_act = 0; push_result(ev); return;
    end
    pos = t + p_pos;
    while (p_ptr < p_cnt_a) begin
      k = p_bank * MaxNotes + p_ptr;
      if (pos >= longint'($signed(p_end[k]))) begin
        p_ptr++; p_gate = 0; ev = EV_OFF; continue;
      end
      if (pos >= longint'($signed(p_start[k]))) begin
        p_held = p_val[k];
        if (!p_gate) begin
          p_gate = 1; ev = EV_ON;
        end
        push_result(ev); return;
      end
      push_result(drop_gate(ev)); return;
    end
    push_result(drop_gate(ev));
  endfunction

  function automatic void predict_item(in_item_t it);
    int k;
    case (op_e'(it.op))
      OP_TICK: play_tick(longint'(it.tick_time));
      OP_WRITE: begin
        k = (p_bank ^ 1'b1) * MaxNotes + it.entry_index;
        p_start[k] = it.note_start; p_end[k] = it.note_end; p_val[k] = it.note_value;
      end
      OP_COMMIT: begin
        p_off_p = longint'(it.seq_offset); p_len_p = longint'({1'b0, it.seq_length});
        p_cnt_p = it.note_count > MaxNotes ? MaxNotes : it.note_count;
        p_rep_p = it.seq_repeat; p_pend = 1;
      end
      default: ;
    endcase
  endfunction

  // No commit may count an unwritten slot. The bank flips on every swap, which
  // the generator cannot foresee exactly; it therefore fills all 64 slots of
  // one bank, commits and ticks to swap banks, then fills the other bank alike.
  function automatic in_item_t rand_item();
    in_item_t it;
    it = '0;
    it.op = 2'($urandom);
    it.tick_time = $urandom; it.entry_index = 6'($urandom);
    it.note_start = $urandom; it.note_end = $urandom; it.note_value = $urandom;
    it.seq_offset = $urandom; it.seq_length = 31'($urandom);
    it.seq_repeat = 1'($urandom); it.note_count = 7'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_write(int idx, int s, int e, int v);
    in_item_t it;
    it = rand_item();
    it.op = OP_WRITE; it.entry_index = idx[5:0];
    it.note_start = s; it.note_end = e; it.note_value = v;
    return it;
  endfunction

  function automatic in_item_t mk_commit(int off, int len, bit rep, int cnt);
    in_item_t it;
    it = rand_item();
    it.op = OP_COMMIT; it.seq_offset = off; it.seq_length = len[30:0];
    it.seq_repeat = rep; it.note_count = cnt[6:0];
    return it;
  endfunction

  function automatic in_item_t mk_tick(int t);
    in_item_t it;
    it = rand_item();
    it.op = OP_TICK; it.tick_time = t;
    return it;
  endfunction

  // A musically sane random sequence: sorted notes over a short loop.
  function automatic void queue_sequence(int n_ticks);
    int cnt, len, off, cur, t, step;
    cnt = $urandom_range(0, 8) == 0 ? $urandom_range(0, 70) : $urandom_range(1, 6);
    len = $urandom_range(2, 16) * int'(Beat) +
          ($urandom_range(0, 1) ? $urandom_range(0, 65535) : 0);
    off = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 4) * int'(Beat);
    cur = 0;
    for (int i = 0; i < 64; i++) begin
      if (i < cnt) begin
        cur += $urandom_range(0, int'(Beat));
        t = cur + $urandom_range(1, 2 * int'(Beat));
        pending_items.push_back(mk_write(i, cur, t, int'($urandom)));
        cur = t + $urandom_range(0, int'(Beat) / 2);
      end
    end
    pending_items.push_back(mk_commit(off, len, 1'($urandom), cnt));
    t = $urandom_range(0, 8) * int'(Beat);
    step = $urandom_range(int'(Beat) / 8, int'(Beat));
    for (int i = 0; i < n_ticks; i++) begin
      pending_items.push_back(mk_tick(t));
      t += step;
      if ($urandom_range(0, 15) == 0) t = $urandom_range(0, 4) * int'(Beat) + $urandom_range(0, 999);
    end
  endfunction

  initial begin
    in_item_t it;
    // Fill both banks fully so every later read hits written entries.
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 64; i++) begin
        pending_items.push_back(mk_write(i, i * 65536, i * 65536 + 32768, i));
      end
      pending_items.push_back(mk_commit(0, 1, 0, 0));
      pending_items.push_back(mk_tick(0));
      pending_items.push_back(mk_tick(100));
    end
    // Directed: extremes, unknown op, count clamp, idle and stop, overflow.
    pending_items.push_back(mk_tick(32'h7fffffff));
    pending_items.push_back(mk_tick(32'h80000000));
    it = rand_item(); it.op = OP_NONE; pending_items.push_back(it);
    pending_items.push_back(mk_write(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    pending_items.push_back(mk_write(63, 0, 1, 32'h80000000));
    pending_items.push_back(mk_commit(32'h7fffffff, 31'h7fffffff, 1, 127));
    pending_items.push_back(mk_commit(32'h80000000, 31'h7fffffff, 1, 64));
    pending_items.push_back(mk_tick(0));
    pending_items.push_back(mk_tick(32'h7fffffff));
    pending_items.push_back(mk_tick(32'h7fff0001));
    pending_items.push_back(mk_tick(32'h80000000));
    pending_items.push_back(mk_tick(32'h80000000));
    pending_items.push_back(mk_commit(0, 0, 0, 1));
    pending_items.push_back(mk_tick(5));
    pending_items.push_back(mk_tick(6));
    pending_items.push_back(mk_tick(7));
    // Random part: mostly well-formed sequences, some raw noise items.
    while (pending_items.size() < 1800) begin
      if ($urandom_range(0, 5) == 0) begin
        it = rand_item();
        if (it.op == OP_COMMIT || it.op == OP_WRITE) it.op = OP_TICK;
        pending_items.push_back(it);
      end else begin
        queue_sequence($urandom_range(5, 60));
      end
    end
  end

  // Driver: bursts and gaps; one pause until every result has arrived.
  int burst_left = 0, gap_left = 0, sent = 0;
  bit accepted;
  always @(posedge clk_i) begin
    accepted <= rst_ni && start && !busy;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !accepted) begin
      start <= 1'b1;
    end else begin
      if (accepted) sent = sent + 1;
      if (sent >= 900 && !paused_once && expected_results.size() != 0) begin
        hold_sender = 1;
        paused_once = 1;
      end
      if (hold_sender && expected_results.size() == 0) hold_sender = 0;
      if (hold_sender || pending_items.size() == 0) begin
        start <= 1'b0;
        if (pending_items.size() == 0 && !start) sender_done = 1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        item_i <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: predict at acceptance, then check strobes in order.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) predict_item(item_i);
    if (rst_ni && valid_o) begin
      ticks_seen++;
      if (res_o.gate_event == EV_ON) ons_seen++;
      if (res_o.gate_event == EV_OFF) offs_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: out_value %h gate_event %0d",
               res_o.out_value, res_o.gate_event);
        errors++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (res_o.out_value !== e.out_value) begin
          $error("out_value expected %h actual %h", e.out_value, res_o.out_value);
          errors++;
        end
        if (res_o.gate_event !== e.gate_event) begin
          $error("gate_event expected %0d actual %0d", e.gate_event, res_o.gate_event);
          errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    p_bank = 0; p_act = 0; p_pend = 0; p_started = 0; p_gate = 0;
    p_rep_a = 0; p_rep_p = 0; p_last = 0; p_pos = 0; p_off_a = 0; p_len_a = 0;
    p_off_p = 0; p_len_p = 0; p_ptr = 0; p_cnt_a = 0; p_cnt_p = 0; p_held = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (sender_done && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Played %0d ticks with %0d note-on and %0d note-off events.",
             ticks_seen, ons_seen, offs_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/nsp_pkg.sv
hdl/nsp_datapath.sv
hdl/nsp_ctrl.sv
hdl/note_sequence_player_top.sv
bench/tb.sv
